// File: sv/itp_pkg.sv
package itp_pkg;

	localparam int unsigned CHAR_W = 8;

	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
	localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_OPEN   = 8'h28;
	localparam logic [CHAR_W-1:0] CH_CLOSE  = 8'h29;
	localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNMATCHED = 2'd2;
	localparam logic [1:0] ST_DONE      = 2'd3;

	typedef logic [CHAR_W-1:0] char_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stack_cmd_t;

	function automatic logic [1:0] op_prec(input char_t c);
		logic [1:0] p;
		p = 2'd1;
		if (c == CH_CARET) begin
			p = 2'd3;
		end else if (c == CH_STAR || c == CH_SLASH) begin
			p = 2'd2;
		end
		return p;
	endfunction

	function automatic logic is_letter(input char_t c);
		return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
	endfunction

	// True when stacked operator t must leave before operator c is pushed.
	function automatic logic must_pop(input char_t t, input char_t c);
		logic [1:0] p;
		logic [1:0] q;
		p = op_prec(c);
		q = op_prec(t);
		return (t != CH_OPEN) && ((q > p) || ((q == p) && (c != CH_CARET)));
	endfunction

endpackage

// File: sv/itp_in_if.sv
interface itp_in_if;
	import itp_pkg::*;

	logic  valid;
	logic  ready;
	char_t symbol;
	logic  end_of_expression;

	modport source (output valid, output symbol, output end_of_expression, input ready);
	modport sink (input valid, input symbol, input end_of_expression, output ready);

endinterface

// File: sv/itp_out_if.sv
interface itp_out_if;
	import itp_pkg::*;

	logic       valid;
	logic       ready;
	char_t      out_char;
	logic       has_char;
	logic [1:0] status;
	logic       run_last;

	modport source (output valid, output out_char, output has_char, output status,
		output run_last, input ready);
	modport sink (input valid, input out_char, input has_char, input status,
		input run_last, output ready);

endinterface

// File: sv/infix_to_postfix_converter_unit.sv
// Infix to postfix converter.
// The symbols channel takes one infix character per word together with an
// end-of-expression flag. The results channel returns postfix characters,
// status codes and a run_last flag that marks the final result of each input.
// Operators wait in a row of cells that forms the stack; the top sits in the
// first cell and every push or pop shifts the whole row by one place.
// Each input passes an accept step, a symbol stage that pops and emits
// operators one at a time until the symbol can be pushed or placed, and a
// finish stage that, at end of expression, flushes the stack and then returns
// ST_DONE. The first result of an input is registered by its symbol stage, or
// by its finish stage when the symbol itself releases nothing; an input that
// releases nothing and does not end the expression returns no result.
// A new input is taken only after the previous one has finished processing.
// When the receiver stalls, the output register holds its word and processing
// pauses until the word is taken.
// Reset empties the stack and the output register; no clearing pass is needed.
module infix_to_postfix_converter_unit
	import itp_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	itp_in_if.sink    symbols,
	itp_out_if.source results
);

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SYM  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t     state_q, state_d;
	char_t      sym_q;
	logic       fin_q;
	logic [CW-1:0] count_q;

	logic       out_valid_q;
	char_t      out_char_q;
	logic       has_char_q;
	logic [1:0] status_q;
	logic       run_last_q;

	stack_cmd_t cmd;
	char_t      cell_val [STACK_DEPTH];
	char_t      top, second;
	logic       step, full, empty, deep;
	logic       emit, e_has, e_last;
	char_t      e_char;
	logic [1:0] e_status;

	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			char_t above_w, below_w;
			if (gi == 0) begin : g_first
				assign above_w = sym_q;
			end else begin : g_mid
				assign above_w = cell_val[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_last
				assign below_w = CH_NUL;
			end else begin : g_inner
				assign below_w = cell_val[gi+1];
			end
			itp_cell u_cell (
				.clk   (clk),
				.cmd   (cmd),
				.above (above_w),
				.below (below_w),
				.value (cell_val[gi])
			);
		end
	endgenerate

	assign top    = cell_val[0];
	assign second = cell_val[1];
	assign full   = (count_q == CW'(STACK_DEPTH));
	assign empty  = (count_q == '0);
	assign deep   = (count_q >= CW'(2));
	assign step   = (state_q != S_IDLE) && (!out_valid_q || results.ready);

	assign symbols.ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		emit     = 1'b0;
		e_char   = CH_NUL;
		e_has    = 1'b0;
		e_status = ST_OK;
		e_last   = 1'b0;
		if (step) begin
			case (state_q)
				S_SYM: begin
					state_d = S_FIN;
					if (sym_q == CH_NUL) begin
						state_d = S_FIN;
					end else if (is_letter(sym_q)) begin
						emit   = 1'b1;
						e_char = sym_q;
						e_has  = 1'b1;
						e_last = !fin_q;
					end else if (sym_q == CH_CLOSE) begin
						if (empty) begin
							emit     = 1'b1;
							e_status = ST_UNMATCHED;
							e_last   = !fin_q;
						end else if (top == CH_OPEN) begin
							cmd.pop = 1'b1;
						end else begin
							cmd.pop = 1'b1;
							emit    = 1'b1;
							e_char  = top;
							e_has   = 1'b1;
							e_last  = !fin_q && deep && (second == CH_OPEN);
							state_d = S_SYM;
						end
					end else if (sym_q != CH_OPEN && !empty && must_pop(top, sym_q)) begin
						cmd.pop = 1'b1;
						emit    = 1'b1;
						e_char  = top;
						e_has   = 1'b1;
						e_last  = !fin_q && !(deep && must_pop(second, sym_q));
						state_d = S_SYM;
					end else if (full) begin
						emit     = 1'b1;
						e_status = ST_OVERFLOW;
						e_last   = !fin_q;
					end else begin
						cmd.push = 1'b1;
					end
				end
				S_FIN: begin
					if (!fin_q) begin
						state_d = S_IDLE;
					end else if (!empty) begin
						cmd.pop = 1'b1;
						if (top != CH_OPEN) begin
							emit   = 1'b1;
							e_char = top;
							e_has  = 1'b1;
						end
					end else begin
						emit     = 1'b1;
						e_status = ST_DONE;
						e_last   = 1'b1;
						state_d  = S_IDLE;
					end
				end
				default: begin
					state_d = S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (symbols.valid && symbols.ready) begin
				state_q <= S_SYM;
			end else begin
				state_q <= state_d;
			end
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (symbols.valid && symbols.ready) begin
			sym_q <= symbols.symbol;
			fin_q <= symbols.end_of_expression;
		end
		if (emit) begin
			out_char_q <= e_char;
			has_char_q <= e_has;
			status_q   <= e_status;
			run_last_q <= e_last;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.out_char = out_char_q;
	assign results.has_char = has_char_q;
	assign results.status   = status_q;
	assign results.run_last = run_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !full)
		else $error("push into a full stack");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !empty)
		else $error("pop from an empty stack");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(symbols.valid && symbols.ready) |=> (state_q == S_SYM))
		else $error("accepted word did not start processing");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |=> (out_valid_q && $stable(out_char_q)
			&& $stable(status_q) && $stable(run_last_q)))
		else $error("result overwritten while stalled");

endmodule

// File: sv/itp_cell.sv
module itp_cell
	import itp_pkg::*;
(
	input  logic       clk,
	input  stack_cmd_t cmd,
	input  char_t      above,
	input  char_t      below,
	output char_t      value
);

	char_t value_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			value_q <= above;
		end else if (cmd.pop) begin
			value_q <= below;
		end
	end

	assign value = value_q;

endmodule
